>>> rtl/core/k_nearest_neighbor_finder_assert.svh
// Assertion macros for the neighbor finder.
`ifndef K_NEAREST_NEIGHBOR_FINDER_ASSERT_SVH
`define K_NEAREST_NEIGHBOR_FINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KNN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("knn: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("knn: next-cycle check failed");

`endif

>>> rtl/core/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types, constants and codes of the k-nearest-neighbor finder.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

    localparam int AGENT_SLOTS_DEF    = 16;
    localparam int NEIGHBORS_KEPT_DEF = 4;

    localparam logic [15:0] RANGE_RESET = 16'd46341;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_NEIGHBOR_RANGE = 1'b0;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // arithmetic widths: 17-bit differences, 33-bit sum of squares
    localparam int DIFF_W = 17;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = 33;
    localparam int DIST_W = 17;
    localparam int REC_W  = 48;

    localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 1);

    typedef struct packed {
        logic               req_type;
        logic [3:0]         agent_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        heading_in;
        logic               active_in;
    } t_in;

    typedef struct packed {
        logic [3:0]  neighbor_id;
        logic        neighbor_valid;
        logic [15:0] distance_out;
        logic [15:0] relative_heading;
        logic        last;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QLATCH,
        ST_SCAN,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_OFFER,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic sel_in_addr;
        logic write_rec;
        logic start_query;
        logic latch_q;
        logic next_cand;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic offer;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic q_ok;
        logic cand_ok;
        logic cand_last;
        logic root_last;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/knn_ram.sv
// ----------------------------------------------------------------------------
// knn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer: record writes, query fetch, per-candidate distance steps,
// square-root iterations and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_type,
    input  wire knn_pkg::t_stat i_stat,
    output knn_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    knn_pkg::t_state r_state;
    knn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            knn_pkg::ST_IDLE: begin
                o_in_stall        = 1'b0;
                o_cmd.sel_in_addr = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == knn_pkg::REQ_QUERY) begin
                        o_cmd.start_query = 1'b1;
                        n_state           = knn_pkg::ST_QLATCH;
                    end else begin
                        o_cmd.write_rec = 1'b1;
                    end
                end
            end
            knn_pkg::ST_QLATCH: begin
                o_cmd.latch_q = 1'b1;
                n_state = i_stat.q_ok ? knn_pkg::ST_SCAN : knn_pkg::ST_EMIT;
            end
            knn_pkg::ST_SCAN: begin
                // read of the candidate record is in flight when it qualifies
                if (i_stat.cand_ok) begin
                    n_state = knn_pkg::ST_DIFF;
                end else if (i_stat.cand_last) begin
                    n_state = knn_pkg::ST_EMIT;
                end else begin
                    o_cmd.next_cand = 1'b1;
                end
            end
            knn_pkg::ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = knn_pkg::ST_SQX;
            end
            knn_pkg::ST_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = knn_pkg::ST_SQY;
            end
            knn_pkg::ST_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = knn_pkg::ST_ROOT;
            end
            knn_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_last) begin
                    n_state = knn_pkg::ST_OFFER;
                end
            end
            knn_pkg::ST_OFFER: begin
                o_cmd.offer = 1'b1;
                if (i_stat.cand_last) begin
                    n_state = knn_pkg::ST_EMIT;
                end else begin
                    o_cmd.next_cand = 1'b1;
                    n_state         = knn_pkg::ST_SCAN;
                end
            end
            knn_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = knn_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = knn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/knn_dp.sv
// ----------------------------------------------------------------------------
// knn_dp
// Datapath: record table, active flags, distance arithmetic with a shared
// squarer and bit-serial square root, sorted kept list and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_dp #(
    parameter int AGENT_SLOTS    = knn_pkg::AGENT_SLOTS_DEF,
    parameter int NEIGHBORS_KEPT = knn_pkg::NEIGHBORS_KEPT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire knn_pkg::t_cmd  i_cmd,
    output knn_pkg::t_stat      o_stat,
    input  wire knn_pkg::t_in   i_in_data,
    input  wire logic [15:0]    i_range,
    output logic                o_out_valid,
    output knn_pkg::t_out       o_out_data,
    input  wire logic           i_out_stall
);

    localparam int AW = $clog2(AGENT_SLOTS);
    localparam int IW = ((AW > 4) ? AW : 4) + 1;
    localparam int KN = NEIGHBORS_KEPT;
    localparam int KW = (KN > 1) ? $clog2(KN) : 1;

    // input slot decode
    logic [IW-1:0] in_idx_ext;
    logic          in_range_ok;
    logic [AW-1:0] in_addr;

    assign in_idx_ext  = IW'(i_in_data.agent_index);
    assign in_range_ok = in_idx_ext < IW'(AGENT_SLOTS);
    assign in_addr     = in_idx_ext[AW-1:0];

    // record table
    logic                     ram_we;
    logic [AW-1:0]            ram_raddr;
    logic [knn_pkg::REC_W-1:0] ram_wdata;
    logic [knn_pkg::REC_W-1:0] ram_rdata;
    logic signed [15:0]       rd_x;
    logic signed [15:0]       rd_y;
    logic [15:0]              rd_h;

    logic [AW-1:0] r_cand;

    assign ram_we    = i_cmd.write_rec && in_range_ok;
    assign ram_wdata = {i_in_data.pos_x, i_in_data.pos_y, i_in_data.heading_in};
    assign ram_raddr = i_cmd.sel_in_addr ? in_addr : r_cand;
    assign rd_x      = ram_rdata[47:32];
    assign rd_y      = ram_rdata[31:16];
    assign rd_h      = ram_rdata[15:0];

    knn_ram #(
        .WIDTH (knn_pkg::REC_W),
        .DEPTH (AGENT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [2**AW-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (ram_we) begin
            r_active[in_addr] <= i_in_data.active_in;
        end
    end

    // query record
    logic [AW-1:0]      r_qidx;
    logic               r_q_ok;
    logic signed [15:0] r_qx;
    logic signed [15:0] r_qy;
    logic [15:0]        r_qh;

    // distance arithmetic
    logic signed [knn_pkg::DIFF_W-1:0] r_dx;
    logic signed [knn_pkg::DIFF_W-1:0] r_dy;
    logic [15:0]                       r_rel;
    logic signed [knn_pkg::DIFF_W-1:0] mul_in;
    logic signed [knn_pkg::PROD_W-1:0] prod;
    logic [knn_pkg::SQ_W-1:0]          sq;
    logic [knn_pkg::SQ_W-1:0]          r_acc;
    logic [knn_pkg::SQ_W-1:0]          r_root;
    logic [knn_pkg::SQ_W-1:0]          r_bit;
    logic [knn_pkg::SQ_W:0]            trial;
    logic                              trial_fits;

    assign mul_in     = i_cmd.sq_x ? r_dx : r_dy;
    assign prod       = mul_in * mul_in;
    assign sq         = prod[knn_pkg::SQ_W-1:0];
    assign trial      = {1'b0, r_root} + {1'b0, r_bit};
    assign trial_fits = {1'b0, r_acc} >= trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_qidx <= in_addr;
            r_q_ok <= in_range_ok && r_active[in_addr];
            r_cand <= '0;
        end else if (i_cmd.next_cand) begin
            r_cand <= r_cand + AW'(1);
        end
        if (i_cmd.latch_q) begin
            r_qx <= rd_x;
            r_qy <= rd_y;
            r_qh <= rd_h;
        end
        if (i_cmd.diff) begin
            r_dx  <= knn_pkg::DIFF_W'(rd_x) - knn_pkg::DIFF_W'(r_qx);
            r_dy  <= knn_pkg::DIFF_W'(rd_y) - knn_pkg::DIFF_W'(r_qy);
            r_rel <= rd_h - r_qh;
        end
        if (i_cmd.sq_x) begin
            r_acc <= sq;
        end else if (i_cmd.sq_y) begin
            r_acc <= r_acc + sq;
        end else if (i_cmd.root_step && trial_fits) begin
            r_acc <= r_acc - trial[knn_pkg::SQ_W-1:0];
        end
        if (i_cmd.sq_y) begin
            r_root <= '0;
            r_bit  <= knn_pkg::ROOT_BIT_INIT;
        end else if (i_cmd.root_step) begin
            if (trial_fits) begin
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // kept list, sorted by (distance, id); valid entries form a prefix
    logic [KN-1:0] r_kv;
    logic [KN-1:0] n_kv;
    logic [AW-1:0] r_kid  [KN];
    logic [AW-1:0] n_kid  [KN];
    logic [15:0]   r_kd   [KN];
    logic [15:0]   n_kd   [KN];
    logic [15:0]   r_krel [KN];
    logic [15:0]   n_krel [KN];

    logic [knn_pkg::DIST_W-1:0] cand_dist;
    logic                       in_reach;
    logic [KN-1:0]              le;
    logic [KN:0]                le_ext;

    assign cand_dist = r_root[knn_pkg::DIST_W-1:0];
    assign in_reach  = cand_dist <= {1'b0, i_range};

    // the last entry counts only when strictly nearer: a tie there is displaced
    always_comb begin
        for (int k = 0; k < KN; k++) begin
            le[k] = r_kv[k] && ((r_kd[k] < cand_dist[15:0]) ||
                                ((r_kd[k] == cand_dist[15:0]) && (k != KN - 1)));
        end
        le_ext = {le, 1'b1};
    end

    always_comb begin
        n_kv   = r_kv;
        n_kid  = r_kid;
        n_kd   = r_kd;
        n_krel = r_krel;
        if (i_cmd.start_query) begin
            n_kv = '0;
        end else if (i_cmd.offer && in_reach) begin
            // a later candidate has a higher id, so it goes after equal distances;
            // a tie with the last entry of a full list takes its place,
            // farther than that and nothing moves
            for (int k = 0; k < KN; k++) begin
                if (!le[k] && le_ext[k]) begin
                    n_kv[k]   = 1'b1;
                    n_kid[k]  = r_cand;
                    n_kd[k]   = cand_dist[15:0];
                    n_krel[k] = r_rel;
                end
            end
            for (int k = 1; k < KN; k++) begin
                if (!le[k] && !le_ext[k]) begin
                    n_kv[k]   = r_kv[k-1];
                    n_kid[k]  = r_kid[k-1];
                    n_kd[k]   = r_kd[k-1];
                    n_krel[k] = r_krel[k-1];
                end
            end
        end else if (i_cmd.emit) begin
            for (int k = 0; k < KN - 1; k++) begin
                n_kv[k]   = r_kv[k+1];
                n_kid[k]  = r_kid[k+1];
                n_kd[k]   = r_kd[k+1];
                n_krel[k] = r_krel[k+1];
            end
            n_kv[KN-1] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= '0;
        end else begin
            r_kv <= n_kv;
        end
        r_kid  <= n_kid;
        r_kd   <= n_kd;
        r_krel <= n_krel;
    end

    // result emission
    logic [KW-1:0]  r_emit;
    logic           emit_last;
    logic           n_out_valid;
    knn_pkg::t_out  n_out_data;

    assign emit_last = r_emit == KW'(KN - 1);

    always_comb begin
        n_out_data.neighbor_valid   = r_kv[0];
        n_out_data.neighbor_id      = r_kv[0] ? 4'(r_kid[0]) : 4'd0;
        n_out_data.distance_out     = r_kv[0] ? r_kd[0] : 16'd0;
        n_out_data.relative_heading = r_kv[0] ? r_krel[0] : 16'd0;
        n_out_data.last             = emit_last;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = o_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= n_out_valid;
        end
        if (i_cmd.emit) begin
            o_out_data <= n_out_data;
        end
        if (i_cmd.start_query) begin
            r_emit <= '0;
        end else if (i_cmd.emit) begin
            r_emit <= r_emit + KW'(1);
        end
    end

    assign o_stat.q_ok      = r_q_ok;
    assign o_stat.cand_ok   = r_active[r_cand] && (r_cand != r_qidx);
    assign o_stat.cand_last = r_cand == AW'(AGENT_SLOTS - 1);
    assign o_stat.root_last = r_bit[0];
    assign o_stat.out_free  = !o_out_valid || !i_out_stall;
    assign o_stat.emit_last = emit_last;

endmodule

`default_nettype wire

>>> rtl/core/k_nearest_neighbor_finder.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbor_finder
// Keeps a table of agent records and reports the nearest active agents of a
// queried agent, nearest first, with distance and relative heading.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                                   Payload
// in        input      i_in_valid / o_in_stall                   knn_pkg::t_in
// out       output     o_out_valid / i_out_stall                 knn_pkg::t_out
// config    APB        psel penable pwrite paddr pwdata prdata   neighbor_range
//
// A query scans every one of the AGENT_SLOTS records, and the 17-step bit-serial
// square root of each active candidate dominates its work. An inactive or
// out-of-table querying agent skips the scan. The block works on one item at a
// time; results leave through a registered output stage, and output stalls
// stretch only the emission phase. Reset is synchronous and clears the active
// flags, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_nearest_neighbor_finder_assert.svh"

module k_nearest_neighbor_finder #(
    parameter int AGENT_SLOTS    = knn_pkg::AGENT_SLOTS_DEF,
    parameter int NEIGHBORS_KEPT = knn_pkg::NEIGHBORS_KEPT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire knn_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output knn_pkg::t_out                      o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [knn_pkg::APB_AW-1:0]    paddr,
    input  wire logic [knn_pkg::APB_DW-1:0]    pwdata,
    output logic [knn_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    logic [15:0] r_range;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == knn_pkg::REG_NEIGHBOR_RANGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= knn_pkg::RANGE_RESET;
        end else if (cfg_write) begin
            r_range <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[2] == knn_pkg::REG_NEIGHBOR_RANGE) begin
            prdata = knn_pkg::APB_DW'(r_range);
        end else begin
            prdata = '0;
        end
    end

    knn_pkg::t_cmd  cmd;
    knn_pkg::t_stat stat;

    knn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    knn_dp #(
        .AGENT_SLOTS    (AGENT_SLOTS),
        .NEIGHBORS_KEPT (NEIGHBORS_KEPT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_range     (r_range),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    logic query_xfer;
    logic empty_result;
    logic empty_payload_zero;
    logic valid_result;
    logic reach_ok;

    assign query_xfer         = i_in_valid && !o_in_stall
                                && (i_in_data.req_type == knn_pkg::REQ_QUERY);
    assign empty_result       = o_out_valid && !o_out_data.neighbor_valid;
    assign empty_payload_zero = (o_out_data.neighbor_id == 4'd0)
                                && (o_out_data.distance_out == 16'd0)
                                && (o_out_data.relative_heading == 16'd0);
    assign valid_result       = o_out_valid && o_out_data.neighbor_valid;
    assign reach_ok           = o_out_data.distance_out <= r_range;

    // a query transfer must be followed by a closed input
    `KNN_ASSERT_NEXT(a_query_blocks_input, i_clk, i_rst_n, query_xfer, o_in_stall)
    // empty slots carry zero payload
    `KNN_ASSERT_NOW(a_empty_slot_zero, i_clk, i_rst_n, empty_result, empty_payload_zero)
    // a reported neighbor never lies beyond the range register
    `KNN_ASSERT_NOW(a_kept_in_range, i_clk, i_rst_n, valid_result, reach_ok)

endmodule

`default_nettype wire

>>> tb/k_nearest_neighbor_finder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_neighbor_finder_checker
// Watches the input, output and register ports of the neighbor finder. It
// keeps its own agent table and range setting, works out the kept results of
// every accepted query, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_finder_checker #(
    parameter int AGENT_SLOTS    = knn_pkg::AGENT_SLOTS_DEF,
    parameter int NEIGHBORS_KEPT = knn_pkg::NEIGHBORS_KEPT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire knn_pkg::t_in               i_in_data,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire knn_pkg::t_out              i_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [knn_pkg::APB_AW-1:0] paddr,
    input  wire logic [knn_pkg::APB_DW-1:0] pwdata,
    input  wire logic                       pready,
    output int                              o_mismatch_count,
    output int                              o_pending
);

    logic signed [15:0] x_tab [AGENT_SLOTS];
    logic signed [15:0] y_tab [AGENT_SLOTS];
    logic [15:0]        heading_tab [AGENT_SLOTS];
    logic               active_tab [AGENT_SLOTS];
    logic [15:0]        neighbor_range;
    knn_pkg::t_out      expected_neighbors [$];

    function automatic int unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, probe, rem;
        root  = 0;
        rem   = v;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return 32'(root);
    endfunction

    // farther, or same distance and higher id
    function automatic bit ranks_behind(input int unsigned da, input int unsigned ia,
                                        input int unsigned db, input int unsigned ib);
        return (da > db) || (da == db && ia > ib);
    endfunction

    task automatic predict_neighbors(input logic [3:0] qi);
        int unsigned     kid [NEIGHBORS_KEPT];
        int unsigned     kdist [NEIGHBORS_KEPT];
        int unsigned     d, tmp_id, tmp_dist;
        int              n, far;
        longint signed   dx, dy;
        longint unsigned sumsq;
        knn_pkg::t_out   r;
        n = 0;
        for (int k = 0; k < NEIGHBORS_KEPT; k++) begin
            kid[k]   = 0;
            kdist[k] = neighbor_range;
        end
        if (int'(qi) < AGENT_SLOTS && active_tab[qi]) begin
            for (int c = 0; c < AGENT_SLOTS; c++) begin
                if (c != int'(qi) && active_tab[c]) begin
                    dx    = longint'(x_tab[c]) - longint'(x_tab[qi]);
                    dy    = longint'(y_tab[c]) - longint'(y_tab[qi]);
                    sumsq = longint'(dx * dx) + longint'(dy * dy);
                    d     = int_sqrt(sumsq);
                    if (d <= neighbor_range) begin
                        if (n < NEIGHBORS_KEPT) begin
                            kid[n]   = c;
                            kdist[n] = d;
                            n++;
                        end else begin
                            // full list: an equal distance still displaces the farthest
                            far = 0;
                            for (int k = 1; k < NEIGHBORS_KEPT; k++)
                                if (ranks_behind(kdist[k], kid[k], kdist[far], kid[far]))
                                    far = k;
                            if (d <= kdist[far]) begin
                                kid[far]   = c;
                                kdist[far] = d;
                            end
                        end
                    end
                end
            end
        end
        for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && ranks_behind(kdist[j-1], kid[j-1], kdist[j], kid[j]);
                 j--) begin
                tmp_id     = kid[j];
                tmp_dist   = kdist[j];
                kid[j]     = kid[j-1];
                kdist[j]   = kdist[j-1];
                kid[j-1]   = tmp_id;
                kdist[j-1] = tmp_dist;
            end
        end
        for (int k = 0; k < NEIGHBORS_KEPT; k++) begin
            r = '0;
            if (k < n) begin
                r.neighbor_id      = kid[k][3:0];
                r.neighbor_valid   = 1'b1;
                r.distance_out     = kdist[k][15:0];
                r.relative_heading = 16'(heading_tab[kid[k]] - heading_tab[qi]);
            end
            r.last = (k == NEIGHBORS_KEPT - 1);
            expected_neighbors = {expected_neighbors, r};
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        knn_pkg::t_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < AGENT_SLOTS; s++) begin
                x_tab[s]       = '0;
                y_tab[s]       = '0;
                heading_tab[s] = '0;
                active_tab[s]  = 1'b0;
            end
            neighbor_range = knn_pkg::RANGE_RESET;
            expected_neighbors.delete();
            o_mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[knn_pkg::APB_AW-1:2] == knn_pkg::REG_NEIGHBOR_RANGE)
                neighbor_range = pwdata[15:0];
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == knn_pkg::REQ_WRITE) begin
                    if (int'(i_in_data.agent_index) < AGENT_SLOTS) begin
                        x_tab[i_in_data.agent_index]       = i_in_data.pos_x;
                        y_tab[i_in_data.agent_index]       = i_in_data.pos_y;
                        heading_tab[i_in_data.agent_index] = i_in_data.heading_in;
                        active_tab[i_in_data.agent_index]  = i_in_data.active_in;
                    end
                end else begin
                    predict_neighbors(i_in_data.agent_index);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_neighbors.size() == 0) begin
                    $error("unexpected result transfer: neighbor_id %0d",
                           i_out_data.neighbor_id);
                    o_mismatch_count++;
                end else begin
                    want = expected_neighbors.pop_front();
                    compare_field("neighbor_id", want.neighbor_id, i_out_data.neighbor_id);
                    compare_field("neighbor_valid", want.neighbor_valid,
                                  i_out_data.neighbor_valid);
                    compare_field("distance_out", want.distance_out, i_out_data.distance_out);
                    compare_field("relative_heading", want.relative_heading,
                                  i_out_data.relative_heading);
                    compare_field("last", want.last, i_out_data.last);
                end
            end
        end
        o_pending <= expected_neighbors.size();
    end

endmodule

>>> tb/k_nearest_neighbor_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_neighbor_finder_tb
// Loads agent records and issues neighbor queries: a directed set of corner
// positions, ties and inactive agents, then clustered random traffic under
// several range settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_finder_tb;

    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 42;
    localparam logic [knn_pkg::APB_AW-1:0] RANGE_ADDR =
        knn_pkg::APB_AW'({knn_pkg::REG_NEIGHBOR_RANGE, 2'b00});

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    knn_pkg::t_in               in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    knn_pkg::t_out              out_data;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [knn_pkg::APB_AW-1:0] paddr     = '0;
    logic [knn_pkg::APB_DW-1:0] pwdata    = '0;
    logic [knn_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       calm      = 1'b0;
    int                         idle_cycles;
    int                         mismatch_count;
    int                         pending;

    k_nearest_neighbor_finder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    k_nearest_neighbor_finder_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("k_nearest_neighbor_finder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic knn_pkg::t_in record_item(input logic [3:0] idx,
                                                 input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic [15:0] hdg,
                                                 input logic act);
        knn_pkg::t_in it;
        it.req_type    = knn_pkg::REQ_WRITE;
        it.agent_index = idx;
        it.pos_x       = x;
        it.pos_y       = y;
        it.heading_in  = hdg;
        it.active_in   = act;
        return it;
    endfunction

    // position, heading and flag are don't-care on a query; fill them anyway
    function automatic knn_pkg::t_in query_item(input logic [3:0] idx);
        knn_pkg::t_in it;
        it             = knn_pkg::t_in'($bits(knn_pkg::t_in)'({$urandom, $urandom}));
        it.req_type    = knn_pkg::REQ_QUERY;
        it.agent_index = idx;
        return it;
    endfunction

    function automatic logic signed [15:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 16'($urandom_range(0, 16) * 32 - 256);   // coarse grid: many ties
        else if (pick < 80)
            return 16'($urandom_range(0, 2000) - 1000);
        else if (pick < 90)
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sd32767;
                2:       return 16'sd0;
                default: return -16'sd1;
            endcase
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] random_heading();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic knn_pkg::t_in random_item();
        if ($urandom_range(0, 99) < 55)
            return record_item(4'($urandom_range(0, 15)), random_coord(), random_coord(),
                               random_heading(), $urandom_range(0, 99) < 80);
        return query_item(4'($urandom_range(0, 15)));
    endfunction

    task automatic send_item(input knn_pkg::t_in it);
        while (!calm && $urandom_range(0, 99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // drain all results, then give a trailing record write time to finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_range(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RANGE_ADDR;
        pwdata  <= knn_pkg::APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] ranges [5];
        ranges = '{16'd0, 16'd300, 16'd46341, 16'd2000, 16'($urandom_range(0, 46341))};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, at the reset range
        send_item(query_item(4'd0));                 // empty table
        send_item(record_item(4'd0, 16'sd0, 16'sd0, 16'h0000, 1'b1));
        send_item(query_item(4'd0));                 // only itself active
        send_item(record_item(4'd1, 16'sd32767, 16'sd32767, 16'hFFFF, 1'b1));
        send_item(record_item(4'd2, 16'sh8000, 16'sh8000, 16'h8000, 1'b1));
        send_item(record_item(4'd3, 16'sd100, 16'sd0, 16'h0001, 1'b1));
        send_item(record_item(4'd4, 16'sd0, 16'sd100, 16'hFFFF, 1'b1));
        send_item(record_item(4'd5, -16'sd100, 16'sd0, 16'h1234, 1'b1));
        send_item(record_item(4'd6, 16'sd0, -16'sd100, 16'h7FFF, 1'b0));
        send_item(record_item(4'd7, 16'sd0, -16'sd100, 16'h4000, 1'b1));
        send_item(query_item(4'd0));                 // full list with equal distances
        send_item(query_item(4'd1));                 // opposite corner out of range
        send_item(query_item(4'd2));
        send_item(query_item(4'd6));                 // inactive querying agent
        send_item(record_item(4'd15, 16'sh8000, 16'sd32767, 16'h0001, 1'b1));
        send_item(query_item(4'd15));
        send_item(record_item(4'd9, 16'sd0, 16'sd0, 16'hFFFF, 1'b1));
        send_item(query_item(4'd9));                 // coincident agent
        send_item(record_item(4'd1, 16'sd32767, 16'sd32767, 16'hFFFF, 1'b0));
        send_item(query_item(4'd0));
        send_item(query_item(4'd3));

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                settle();
                calm <= (phase == 2);
                write_range(ranges[phase - 1]);
            end
            repeat (ITEMS_PER_PHASE) send_item(random_item());
        end
        settle();

        if (mismatch_count == 0)
            $display("k_nearest_neighbor_finder test passed");
        else
            $display("k_nearest_neighbor_finder test failed");
        $finish;
    end

endmodule
